@@ hdl/crc_checked_frame_receiver_defines.svh @@
// assertion macros for the frame receiver
// each macro samples on clk and is disabled while rst_n is low
`ifndef CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH
`define CRC_CHECKED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// condition must never hold at a clock edge
`define CRCFR_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("crcfr assertion failed: condition seen");

// when pre holds, post must hold in the following cycle
`define CRCFR_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("crcfr assertion failed: next-cycle check");

// when pre holds, post must hold in the same cycle
`define CRCFR_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("crcfr assertion failed: implication");

`else

`define CRCFR_ASSERT_NEVER(label, cond)
`define CRCFR_ASSERT_NEXT(label, pre, post)
`define CRCFR_ASSERT_IMPLY(label, pre, post)

`endif

`endif

@@ hdl/crcfr_pkg.sv @@
`default_nettype none

package crcfr_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_START_MARK    = 2'd0;
    localparam logic [1:0] REG_END_MARK      = 2'd1;
    localparam logic [1:0] REG_MAX_FRAME_LEN = 2'd2;

    // configuration reset values
    localparam logic [7:0] START_MARK_RST    = 8'd126;
    localparam logic [7:0] END_MARK_RST      = 8'd127;
    localparam logic [7:0] MAX_FRAME_LEN_RST = 8'd255;

    // crc-16, poly 0x1021, msb first
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // header byte positions within a frame
    localparam logic [7:0] POS_FUNCTION = 8'd1;
    localparam logic [7:0] POS_UNIT     = 8'd2;
    localparam logic [7:0] POS_COMMAND  = 8'd3;

    // one result transaction
    typedef struct packed {
        logic       in_frame;
        logic       frame_end;
        logic       frame_good;
        logic       overflow_drop;
        logic [7:0] function_code;
        logic [7:0] unit_id;
        logic [7:0] command_code;
    } result_t;

    // shift one byte into the crc, eight bit steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

@@ hdl/crc_checked_frame_receiver.sv @@
// channel   | valid      | ready      | payload
// ----------+------------+------------+-----------------------------------------
// byte in   | in_valid   | in_ready   | rx_byte
// result    | out_valid  | out_ready  | in_frame, frame_end, frame_good,
//           |            |            | overflow_drop, function_code, unit_id,
//           |            |            | command_code
// config    | cfg_wr_en  | (none)     | cfg_index, cfg_data
//
// one byte per cycle while out_ready keeps the result register drained; the
// result appears in the cycle after the byte is taken, from the byte-wide crc
// update and mark compare feeding the result register.
// in_ready stays high while the result register is empty or being drained,
// so a stall on the result side holds at most one finished transaction.
// rst_n clears frame state, published header and the marks to their defaults.
`default_nettype none
`include "crc_checked_frame_receiver_defines.svh"

module crc_checked_frame_receiver
    import crcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            in_frame,
    output logic            frame_end,
    output logic            frame_good,
    output logic            overflow_drop,
    output logic [7:0]      function_code,
    output logic [7:0]      unit_id,
    output logic [7:0]      command_code,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    // configuration registers
    logic [7:0] start_mark_reg;
    logic [7:0] end_mark_reg;
    logic [7:0] max_frame_len_reg;

    // frame state
    logic        collecting_reg, collecting_next;
    logic        good_flag_reg, good_flag_next;
    logic [7:0]  frame_count_reg, frame_count_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] tail_bytes_reg, tail_bytes_next;
    logic [23:0] hdr_capture_reg, hdr_capture_next;
    logic [23:0] published_reg, published_next;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t result_reg, result_next;

    logic in_accept;
    logic ended;
    logic dropped;
    logic [8:0] frame_len;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mark_reg    <= START_MARK_RST;
            end_mark_reg      <= END_MARK_RST;
            max_frame_len_reg <= MAX_FRAME_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_START_MARK:    start_mark_reg    <= cfg_data;
                REG_END_MARK:      end_mark_reg      <= cfg_data;
                REG_MAX_FRAME_LEN: max_frame_len_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // per-byte frame update
    always_comb
    begin
        collecting_next  = collecting_reg;
        good_flag_next   = good_flag_reg;
        frame_count_next = frame_count_reg;
        running_crc_next = running_crc_reg;
        tail_bytes_next  = tail_bytes_reg;
        hdr_capture_next = hdr_capture_reg;
        published_next   = published_reg;
        ended            = 1'b0;
        dropped          = 1'b0;
        frame_len        = {1'b0, frame_count_reg} + 9'd1;

        if (collecting_reg)
        begin
            // header capture
            case (frame_count_reg)
                POS_FUNCTION: hdr_capture_next[23:16] = rx_byte;
                POS_UNIT:     hdr_capture_next[15:8]  = rx_byte;
                POS_COMMAND:  hdr_capture_next[7:0]   = rx_byte;
                default:      ;
            endcase

            if (rx_byte == end_mark_reg)
            begin
                // close and check; crc sits low byte first in the tail
                collecting_next = 1'b0;
                ended           = 1'b1;
                good_flag_next  = (frame_count_reg >= POS_COMMAND) &&
                                  (running_crc_reg == {tail_bytes_reg[7:0],
                                                       tail_bytes_reg[15:8]});
                if (good_flag_next)
                    published_next = hdr_capture_next;
            end
            else
            begin
                // older tail byte leaves the window into the crc
                if (frame_count_reg >= POS_COMMAND)
                    running_crc_next = crc_feed(running_crc_reg, tail_bytes_reg[15:8]);
                tail_bytes_next = {tail_bytes_reg[7:0], rx_byte};
            end

            frame_count_next = frame_len[7:0];

            // length limit clears everything
            if (frame_len >= {1'b0, max_frame_len_reg})
            begin
                collecting_next  = 1'b0;
                good_flag_next   = 1'b0;
                frame_count_next = '0;
                running_crc_next = '0;
                tail_bytes_next  = '0;
                hdr_capture_next = '0;
                published_next   = '0;
                dropped          = 1'b1;
            end
        end
        else if (rx_byte == start_mark_reg)
        begin
            collecting_next  = 1'b1;
            frame_count_next = 8'd1;
            running_crc_next = '0;
            tail_bytes_next  = '0;
            hdr_capture_next = '0;
        end
    end

    // result assembly
    always_comb
    begin
        result_next.in_frame      = collecting_next;
        result_next.frame_end     = ended;
        result_next.frame_good    = good_flag_next;
        result_next.overflow_drop = dropped;
        result_next.function_code = published_next[23:16];
        result_next.unit_id       = published_next[15:8];
        result_next.command_code  = published_next[7:0];

        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg  <= 1'b0;
            good_flag_reg   <= 1'b0;
            frame_count_reg <= '0;
            running_crc_reg <= '0;
            tail_bytes_reg  <= '0;
            hdr_capture_reg <= '0;
            published_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                collecting_reg  <= collecting_next;
                good_flag_reg   <= good_flag_next;
                frame_count_reg <= frame_count_next;
                running_crc_reg <= running_crc_next;
                tail_bytes_reg  <= tail_bytes_next;
                hdr_capture_reg <= hdr_capture_next;
                published_reg   <= published_next;
            end
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    // outputs
    assign out_valid     = out_valid_reg;
    assign in_frame      = result_reg.in_frame;
    assign frame_end     = result_reg.frame_end;
    assign frame_good    = result_reg.frame_good;
    assign overflow_drop = result_reg.overflow_drop;
    assign function_code = result_reg.function_code;
    assign unit_id       = result_reg.unit_id;
    assign command_code  = result_reg.command_code;

    // checks
    `CRCFR_ASSERT_NEVER(a_end_leaves_frame, out_valid_reg && frame_end && in_frame)
    `CRCFR_ASSERT_IMPLY(a_drop_clears_all, out_valid_reg && overflow_drop, !in_frame && !frame_good && function_code == 8'd0 && unit_id == 8'd0 && command_code == 8'd0)
    `CRCFR_ASSERT_NEXT(a_state_holds_idle, !in_accept, $stable(collecting_reg) && $stable(published_reg))
    `CRCFR_ASSERT_NEXT(a_result_follows_accept, in_accept, out_valid_reg && (in_frame == collecting_reg))

endmodule

`default_nettype wire
